// ===== sv/rgbhsv_pkg.sv =====
package rgbhsv_pkg;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [7:0] hue;
        logic [7:0] saturation;
        logic [7:0] brightness;
    } t_hsv;

    localparam int unsigned QBITS = 8;

    localparam logic [1:0] SEC_RED   = 2'd0;
    localparam logic [1:0] SEC_GREEN = 2'd1;
    localparam logic [1:0] SEC_BLUE  = 2'd2;

endpackage

// ===== sv/rgb_to_hsv_8bit.sv =====
// RGB to HSV converter, 8 bits per channel, hue in two-degree units (0..179).
//
// Request channel: drive i_pixel and raise start; the request is taken at a
// rising edge where start is high and busy is low. busy stays low: a new
// pixel can be taken on every clock.
// Result channel: o_valid is high for exactly one cycle with o_hsv; the
// receiver has to take it then, it cannot hold results off.
// The pipeline has 12 register stages. Throughput: one pixel per clock.
// The depth is set by the two restoring dividers (saturation and hue), one
// quotient bit per stage over 8 stages, plus 3 stages of min/max, constant
// products and hue wrap, and the output register.
// Results leave in request order.
// Reset (i_rst_n low at a clock edge) clears all stage valid bits: pixels in
// flight are dropped and no result follows. Pixel data is not reset.
// Gray and black pixels give hue 0 and saturation 0.
module rgb_to_hsv_8bit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    input  rgbhsv_pkg::t_pixel    i_pixel,
    output logic                  busy,
    output logic                  o_valid,
    output rgbhsv_pkg::t_hsv      o_hsv
);
    import rgbhsv_pkg::*;

    typedef struct packed {
        logic [7:0] s_rem;
        logic [7:0] s_num;
        logic [7:0] s_q;
        logic [8:0] h_rem;
        logic [7:0] h_num;
        logic [7:0] h_q;
        logic [8:0] h_d;
        logic [7:0] hi;
        logic       gray;
    } t_div;

    // one quotient bit of each divider
    function automatic t_div div_step(input t_div d);
        t_div       o;
        logic [8:0] st;
        logic [9:0] ht;
        logic [8:0] sd;
        logic [9:0] hd;
        o  = d;
        st = {d.s_rem, d.s_num[7]};
        ht = {d.h_rem, d.h_num[7]};
        sd = st - {1'b0, d.hi};
        hd = ht - {1'b0, d.h_d};
        if (st >= {1'b0, d.hi}) begin
            o.s_rem = sd[7:0];
            o.s_q   = {d.s_q[6:0], 1'b1};
        end else begin
            o.s_rem = st[7:0];
            o.s_q   = {d.s_q[6:0], 1'b0};
        end
        if (ht >= {1'b0, d.h_d}) begin
            o.h_rem = hd[8:0];
            o.h_q   = {d.h_q[6:0], 1'b1};
        end else begin
            o.h_rem = ht[8:0];
            o.h_q   = {d.h_q[6:0], 1'b0};
        end
        o.s_num = {d.s_num[6:0], 1'b0};
        o.h_num = {d.h_num[6:0], 1'b0};
        return o;
    endfunction

    // stage A: max, min, sector
    logic              r_va;
    logic [7:0]        r_a_hi;
    logic [7:0]        r_a_delta;
    logic [1:0]        r_a_sec;
    logic signed [8:0] r_a_diff;
    logic [7:0]        n_a_hi;
    logic [7:0]        n_a_lo;
    logic [1:0]        n_a_sec;
    logic signed [8:0] n_a_diff;

    // stage B: constant products
    logic               r_vb;
    logic [15:0]        r_b_satn;
    logic signed [14:0] r_b_p60;
    logic [15:0]        r_b_pb;
    logic [16:0]        r_b_wr;
    logic [7:0]         r_b_hi;
    logic [7:0]         r_b_delta;
    logic signed [14:0] n_b_d15;
    logic [15:0]        n_b_pb;

    // stage C: hue numerator
    logic        r_vc;
    logic [16:0] r_c_num;
    logic [15:0] r_c_satn;
    logic [7:0]  r_c_hi;
    logic [7:0]  r_c_delta;
    logic [17:0] n_c_sum;
    logic [16:0] n_c_num;

    // divider stages
    logic [QBITS-1:0] r_dv;
    t_div             r_d [QBITS];
    t_div             n_d [QBITS];
    t_div             n_d_init;

    // output
    logic r_ov;
    t_hsv r_o;

    assign busy = 1'b0;

    always_comb begin
        n_a_hi = i_pixel.red;
        if (i_pixel.green > n_a_hi) n_a_hi = i_pixel.green;
        if (i_pixel.blue > n_a_hi)  n_a_hi = i_pixel.blue;
        n_a_lo = i_pixel.red;
        if (i_pixel.green < n_a_lo) n_a_lo = i_pixel.green;
        if (i_pixel.blue < n_a_lo)  n_a_lo = i_pixel.blue;
        if (n_a_hi == i_pixel.red) begin
            n_a_sec  = SEC_RED;
            n_a_diff = $signed({1'b0, i_pixel.green}) - $signed({1'b0, i_pixel.blue});
        end else if (n_a_hi == i_pixel.green) begin
            n_a_sec  = SEC_GREEN;
            n_a_diff = $signed({1'b0, i_pixel.blue}) - $signed({1'b0, i_pixel.red});
        end else begin
            n_a_sec  = SEC_BLUE;
            n_a_diff = $signed({1'b0, i_pixel.red}) - $signed({1'b0, i_pixel.green});
        end
    end

    always_comb begin
        n_b_d15 = {{6{r_a_diff[8]}}, r_a_diff};
        case (r_a_sec)
            SEC_GREEN: n_b_pb = {1'b0, r_a_delta, 7'd0} - {5'd0, r_a_delta, 3'd0};
            SEC_BLUE:  n_b_pb = {r_a_delta, 8'd0} - {4'd0, r_a_delta, 4'd0};
            default:   n_b_pb = '0;
        endcase
    end

    always_comb begin
        n_c_sum = {{3{r_b_p60[14]}}, r_b_p60} + {2'b00, r_b_pb};
        if (n_c_sum[17]) begin
            n_c_num = n_c_sum[16:0] + r_b_wr;
        end else begin
            n_c_num = n_c_sum[16:0];
        end
    end

    always_comb begin
        n_d_init.s_rem = r_c_satn[15:8];
        n_d_init.s_num = r_c_satn[7:0];
        n_d_init.s_q   = '0;
        n_d_init.h_rem = r_c_num[16:8];
        n_d_init.h_num = r_c_num[7:0];
        n_d_init.h_q   = '0;
        n_d_init.h_d   = {r_c_delta, 1'b0};
        n_d_init.hi    = r_c_hi;
        n_d_init.gray  = (r_c_delta == 8'd0);
        n_d[0] = div_step(n_d_init);
        for (int k = 1; k < QBITS; k++) begin
            n_d[k] = div_step(r_d[k-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_dv <= '0;
            r_ov <= 1'b0;
        end else begin
            r_va <= start & ~busy;
            r_vb <= r_va;
            r_vc <= r_vb;
            r_dv <= {r_dv[QBITS-2:0], r_vc};
            r_ov <= r_dv[QBITS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_hi    <= n_a_hi;
        r_a_delta <= n_a_hi - n_a_lo;
        r_a_sec   <= n_a_sec;
        r_a_diff  <= n_a_diff;

        r_b_satn  <= {r_a_delta, 8'd0} - {8'd0, r_a_delta};
        r_b_p60   <= (n_b_d15 <<< 6) - (n_b_d15 <<< 2);
        r_b_pb    <= n_b_pb;
        r_b_wr    <= {1'b0, r_a_delta, 8'd0} + {3'd0, r_a_delta, 6'd0}
                   + {4'd0, r_a_delta, 5'd0} + {6'd0, r_a_delta, 3'd0};
        r_b_hi    <= r_a_hi;
        r_b_delta <= r_a_delta;

        r_c_num   <= n_c_num;
        r_c_satn  <= r_b_satn;
        r_c_hi    <= r_b_hi;
        r_c_delta <= r_b_delta;

        for (int k = 0; k < QBITS; k++) begin
            r_d[k] <= n_d[k];
        end

        r_o.hue        <= r_d[QBITS-1].gray ? 8'd0 : r_d[QBITS-1].h_q;
        r_o.saturation <= r_d[QBITS-1].gray ? 8'd0 : r_d[QBITS-1].s_q;
        r_o.brightness <= r_d[QBITS-1].hi;
    end

    assign o_valid = r_ov;
    assign o_hsv   = r_o;

endmodule

// ===== test/hsv_checker.sv =====
module hsv_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_busy,
    input  rgbhsv_pkg::t_pixel    i_pixel,
    input  logic                  i_valid,
    input  rgbhsv_pkg::t_hsv      i_hsv,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_checked,
    output int                    o_gray
);
    timeunit 1ns;
    timeprecision 1ps;
    import rgbhsv_pkg::*;

    t_hsv hsv_expected_q[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_gray       = 0;
    end

    function automatic t_hsv hsv_of(input t_pixel px);
        int r, g, b, hi, lo, delta, diff, base, num, q;
        logic [1:0] sector;
        t_hsv res;
        r = px.red;
        g = px.green;
        b = px.blue;
        hi = r;
        lo = r;
        if (g > hi) hi = g;
        if (b > hi) hi = b;
        if (g < lo) lo = g;
        if (b < lo) lo = b;
        delta = hi - lo;
        res.brightness = hi[7:0];
        res.saturation = (hi == 0) ? 8'd0 : 8'((255 * delta) / hi);
        res.hue = 8'd0;
        if (delta != 0) begin
            // ties: red wins over green, green over blue
            if (hi == r) sector = SEC_RED;
            else if (hi == g) sector = SEC_GREEN;
            else sector = SEC_BLUE;
            case (sector)
                SEC_RED: begin
                    diff = g - b;
                    base = 0;
                end
                SEC_GREEN: begin
                    diff = b - r;
                    base = 120;
                end
                default: begin
                    diff = r - g;
                    base = 240;
                end
            endcase
            num = 60 * diff + base * delta;
            if (num < 0) num += 360 * delta;
            q = num / (2 * delta);
            if (q > 179) q = 179;
            res.hue = q[7:0];
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("%0d ns: %s: expected %0d, got %0d", $time, what, want, got);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin : watch
        t_hsv want;
        if (i_rst_n) begin
            // compare before queuing so a stray result cannot consume a fresh request
            if (i_valid) begin
                if (hsv_expected_q.size() == 0) begin
                    report_mismatch("result with no request pending", 0, int'(i_hsv));
                end else begin
                    want = hsv_expected_q.pop_front();
                    if (i_hsv.hue !== want.hue)
                        report_mismatch("hue", int'(want.hue), int'(i_hsv.hue));
                    if (i_hsv.saturation !== want.saturation)
                        report_mismatch("saturation", int'(want.saturation),
                                        int'(i_hsv.saturation));
                    if (i_hsv.brightness !== want.brightness)
                        report_mismatch("brightness", int'(want.brightness),
                                        int'(i_hsv.brightness));
                    o_checked++;
                end
            end
            if (i_start && !i_busy) begin
                hsv_expected_q.insert(hsv_expected_q.size(), hsv_of(i_pixel));
                if (i_pixel.red == i_pixel.green && i_pixel.green == i_pixel.blue)
                    o_gray++;
            end
            o_pending = hsv_expected_q.size();
        end
    end

endmodule

// ===== test/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import rgbhsv_pkg::*;

    localparam int PIXEL_COUNT = 1900;
    localparam int STALL_LIMIT = 500;
    localparam int DRAIN_CYCLES = 24;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   start = 1'b0;
    t_pixel i_pixel = '0;
    logic   busy;
    logic   o_valid;
    t_hsv   o_hsv;

    int fail_count, pending, checked, gray_seen;
    int idle_cycles = 0;

    always #2 i_clk = ~i_clk;

    rgb_to_hsv_8bit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_pixel (i_pixel),
        .busy    (busy),
        .o_valid (o_valid),
        .o_hsv   (o_hsv)
    );

    hsv_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_pixel      (i_pixel),
        .i_valid      (o_valid),
        .i_hsv        (o_hsv),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_gray       (gray_seen)
    );

    function automatic t_pixel px(input int r, input int g, input int b);
        t_pixel p;
        p.red   = r[7:0];
        p.green = g[7:0];
        p.blue  = b[7:0];
        return p;
    endfunction

    function automatic t_pixel random_pixel();
        int kind, m, o, lo_v;
        t_pixel p;
        kind = $urandom_range(0, 9);
        p = px($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
        case (kind)
            5: begin
                m = $urandom_range(0, 255);
                p = px(m, m, m);
            end
            6: begin
                // two channels tied at the maximum
                m = $urandom_range(1, 255);
                o = $urandom_range(0, m);
                case ($urandom_range(0, 2))
                    0: p = px(m, m, o);
                    1: p = px(o, m, m);
                    default: p = px(m, o, m);
                endcase
            end
            7: p = px($urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3));
            8: begin
                lo_v = $urandom_range(0, 1);
                p = px($urandom_range(0, 1) ? 255 - lo_v : lo_v,
                       $urandom_range(0, 1) ? 255 - $urandom_range(0, 1) : $urandom_range(0, 1),
                       $urandom_range(0, 1) ? 255 - $urandom_range(0, 1) : $urandom_range(0, 1));
            end
            default: ;
        endcase
        return p;
    endfunction

    task automatic send_pixel(input t_pixel p);
        @(negedge i_clk);
        start   <= 1'b1;
        i_pixel <= p;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic hold_idle(input int n);
        repeat (n) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
    endtask

    initial begin : watchdog
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((start && !busy) || o_valid || !i_rst_n) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("timeout: no request or result for %0d cycles", STALL_LIMIT);
        $display("tb_top failed");
        $finish;
    end

    initial begin : stimulus
        t_pixel directed[$];
        int sent, burst, gap, k;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // black, white, gray, primaries, ties, hue wrap, saturation extremes
        directed = '{px(0, 0, 0), px(255, 255, 255), px(128, 128, 128), px(1, 1, 1),
                     px(255, 0, 0), px(0, 255, 0), px(0, 0, 255),
                     px(255, 255, 0), px(0, 255, 255), px(255, 0, 255),
                     px(255, 0, 1), px(255, 1, 0), px(1, 0, 0), px(0, 1, 0), px(0, 0, 1),
                     px(255, 254, 254), px(254, 255, 255), px(100, 200, 200),
                     px(200, 100, 200), px(170, 85, 0), px(0, 170, 255),
                     px(127, 128, 129), px(170, 170, 85)};
        foreach (directed[i]) begin
            send_pixel(directed[i]);
            hold_idle($urandom_range(0, 2));
        end

        sent = 0;
        while (sent < PIXEL_COUNT) begin
            burst = $urandom_range(1, 24);
            for (k = 0; k < burst && sent < PIXEL_COUNT; k++) begin
                send_pixel(random_pixel());
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            hold_idle(gap);
        end
        hold_idle(1);

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d pixels converted and compared field by field, %0d gray or black",
                 checked, gray_seen);
        $display("covered: channel extremes, max ties, hue wrap, random bursts with gaps");
        if (fail_count == 0 && pending == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
